// File: design/iem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants of the serial memory bus master.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int unsigned MemBytes  = 256;
  localparam int unsigned PageBytes = 8;
  localparam int unsigned RecoverClocks = 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOTRDY  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_HALF_BIT = 2'd0,
    CFG_POLL_GAP = 2'd1,
    CFG_POLL_LIM = 2'd2,
    CFG_DEV_ADDR = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    U_START = 3'd0,
    U_TX    = 3'd1,
    U_RX    = 3'd2,
    U_STOP  = 3'd3,
    U_REC   = 3'd4,
    U_GAP   = 3'd5,
    U_WAIT  = 3'd6
  } uop_e;

  typedef enum logic [4:0] {
    M_IDLE, M_REC, M_REC_STOP, M_PRB_START, M_PRB_ADDR, M_PRB_STOP,
    M_RD_START, M_RD_ADDR, M_RD_OFF, M_RD_RESTART, M_RD_ADDRR, M_RD_DATA,
    M_END_STOP, M_FAIL_STOP, M_WR_START, M_WR_ADDR, M_WR_OFF, M_WR_WAIT,
    M_WR_DATA, M_WR_STOP, M_PL_START, M_PL_ADDR, M_PL_STOP, M_PL_GAP
  } phase_e;

  typedef struct packed {
    logic        cmd_valid;
    logic        req_type;
    logic [7:0]  req_offset;
    logic [8:0]  req_length;
    logic [7:0]  write_byte;
    logic        write_byte_valid;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        read_last;
    logic        byte_request;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [19:0] poll_gap_ticks;
    logic [9:0]  poll_limit;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [19:0] data;
  } cfg_wr_t;

endpackage

// File: design/iem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface iem_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/iem_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_cfg_regs
// Configuration register bank.
// ----------------------------------------------------------------------------
module iem_cfg_regs
  import iem_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  cfg_wr_t wr_i,
  output cfg_t    cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks <= 16'd250;
      cfg_q.poll_gap_ticks <= 20'd5000;
      cfg_q.poll_limit     <= 10'd600;
      cfg_q.device_address <= 7'd80;
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_i.index))
        CFG_HALF_BIT: cfg_q.half_bit_ticks <= wr_i.data[15:0];
        CFG_POLL_GAP: cfg_q.poll_gap_ticks <= wr_i.data;
        CFG_POLL_LIM: cfg_q.poll_limit     <= wr_i.data[9:0];
        CFG_DEV_ADDR: cfg_q.device_address <= wr_i.data[6:0];
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule

// File: design/iem_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_core
// Bus sequencer: one tick per beat, registered result.
// ----------------------------------------------------------------------------
module iem_core
  import iem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_item_t  in_i,
  output out_item_t res_o
);
  phase_e      phase_q, phase_d;
  uop_e        uop_q, uop_d;
  logic [4:0]  slot_q, slot_d;
  logic [19:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d, addr_q, addr_d;
  logic [8:0]  left_q, left_d;
  logic [6:0]  room_q, room_d;
  logic [9:0]  poll_q, poll_d;
  logic        rdy_q, rdy_d, wr_q, wr_d, ack_q, ack_d;
  out_item_t   o;

  logic [7:0]  aw;
  logic [19:0] len;
  logic [4:0]  s, total;
  logic [9:0]  plim;
  logic [9:0]  sum;

  always_comb begin
    phase_d = phase_q; uop_d = uop_q; slot_d = slot_q; tick_d = tick_q;
    shift_d = shift_q; addr_d = addr_q; left_d = left_q; room_d = room_q;
    poll_d = poll_q; rdy_d = rdy_q; wr_d = wr_q; ack_d = ack_q;
    o = '0; o.scl_out = 1'b1; o.sda_out = 1'b1;
    aw = {cfg_i.device_address, 1'b0};
    s = slot_q;
    plim = (cfg_i.poll_limit == '0) ? 10'd1 : cfg_i.poll_limit;
    sum = {2'b0, in_i.req_offset} + {1'b0, in_i.req_length};
    len = (uop_q == U_GAP) ? cfg_i.poll_gap_ticks : {4'd0, cfg_i.half_bit_ticks};
    if (len == '0) len = 20'd1;
    unique case (uop_q)
      U_START: total = 5'd2;
      U_TX, U_RX: total = 5'd18;
      U_STOP: total = 5'd3;
      U_REC: total = 5'(2 * RecoverClocks);
      default: total = 5'd1;
    endcase

    if (phase_q == M_IDLE) begin
      if (in_i.cmd_valid) begin
        if (sum > 10'(MemBytes)) begin
          o.done_res = 1'b1; o.status = ST_INVALID;
        end else begin
          wr_d = in_i.req_type; addr_d = in_i.req_offset; left_d = in_i.req_length;
          slot_d = '0; tick_d = '0;
          if (!rdy_q) begin
            phase_d = M_REC; uop_d = U_REC;
          end else if (in_i.req_length == '0) begin
            o.done_res = 1'b1; o.status = ST_OK; uop_d = U_WAIT;
          end else if (in_i.req_type) begin
            room_d = 7'(PageBytes - (in_i.req_offset % PageBytes));
            phase_d = M_WR_START; uop_d = U_START;
          end else begin
            phase_d = M_RD_START; uop_d = U_START;
          end
        end
      end
    end else begin
      unique case (uop_q)
        U_START: begin o.scl_out = 1'b1; o.sda_out = (s == 5'd0); end
        U_TX: begin
          o.scl_out = s[0];
          o.sda_out = (s < 5'd16) ? shift_q[3'd7 - s[3:1]] : 1'b1;
        end
        U_RX: begin
          o.scl_out = s[0];
          o.sda_out = (s < 5'd16) ? 1'b1 : !(left_q > 9'd1);
        end
        U_STOP: begin o.scl_out = (s != 5'd0); o.sda_out = (s == 5'd2); end
        U_REC: begin o.scl_out = s[0]; o.sda_out = 1'b1; end
        U_GAP: begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        default: begin o.scl_out = 1'b0; o.sda_out = 1'b1; end
      endcase
      if (uop_q == U_WAIT) begin
        o.byte_request = 1'b1;
        if (in_i.write_byte_valid) begin
          phase_d = M_WR_DATA; uop_d = U_TX; slot_d = '0; tick_d = '0;
          shift_d = in_i.write_byte;
        end
      end else begin
        tick_d = tick_q + 20'd1;
        if (tick_d >= len) begin
          tick_d = '0;
          if (uop_q == U_TX && s == 5'd17) ack_d = !in_i.sda_in;
          if (uop_q == U_RX && s < 5'd16 && s[0]) begin
            shift_d = {shift_q[6:0], in_i.sda_in};
            if (s == 5'd15) begin
              o.read_byte = shift_d; o.read_valid = 1'b1;
              o.read_last = (left_q == 9'd1);
            end
          end
          slot_d = s + 5'd1;
          if (slot_d >= total) begin
            slot_d = '0;
            // Advance the sequencer to the next bus operation.
            priority case (phase_q)
              M_REC: begin phase_d = M_REC_STOP; uop_d = U_STOP; end
              M_REC_STOP: begin phase_d = M_PRB_START; uop_d = U_START; end
              M_PRB_START: begin phase_d = M_PRB_ADDR; uop_d = U_TX; shift_d = aw; end
              M_PRB_ADDR: begin phase_d = M_PRB_STOP; uop_d = U_STOP; end
              M_PRB_STOP: begin
                if (!ack_d) begin
                  phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1; o.status = ST_NOTRDY;
                end else begin
                  rdy_d = 1'b1;
                  if (left_q == '0) begin
                    phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1; o.status = ST_OK;
                  end else if (wr_q) begin
                    room_d = 7'(PageBytes - (addr_q % PageBytes));
                    phase_d = M_WR_START; uop_d = U_START;
                  end else begin
                    phase_d = M_RD_START; uop_d = U_START;
                  end
                end
              end
              M_RD_START: begin phase_d = M_RD_ADDR; uop_d = U_TX; shift_d = aw; end
              M_RD_ADDR, M_WR_ADDR: begin
                if (!ack_d) begin phase_d = M_FAIL_STOP; uop_d = U_STOP; end
                else begin
                  phase_d = (phase_q == M_RD_ADDR) ? M_RD_OFF : M_WR_OFF;
                  uop_d = U_TX; shift_d = addr_q;
                end
              end
              M_RD_OFF: begin
                if (!ack_d) begin phase_d = M_FAIL_STOP; uop_d = U_STOP; end
                else begin phase_d = M_RD_RESTART; uop_d = U_START; end
              end
              M_RD_RESTART: begin
                phase_d = M_RD_ADDRR; uop_d = U_TX; shift_d = aw | 8'd1;
              end
              M_RD_ADDRR: begin
                if (!ack_d) begin phase_d = M_FAIL_STOP; uop_d = U_STOP; end
                else begin phase_d = M_RD_DATA; uop_d = U_RX; shift_d = '0; end
              end
              M_RD_DATA: begin
                left_d = left_q - 9'd1; addr_d = addr_q + 8'd1;
                if (left_d != '0) begin uop_d = U_RX; shift_d = '0; end
                else begin phase_d = M_END_STOP; uop_d = U_STOP; end
              end
              M_WR_START: begin phase_d = M_WR_ADDR; uop_d = U_TX; shift_d = aw; end
              M_WR_OFF: begin
                if (!ack_d) begin phase_d = M_FAIL_STOP; uop_d = U_STOP; end
                else begin phase_d = M_WR_WAIT; uop_d = U_WAIT; end
              end
              M_WR_DATA: begin
                if (!ack_d) begin phase_d = M_FAIL_STOP; uop_d = U_STOP; end
                else begin
                  left_d = left_q - 9'd1; addr_d = addr_q + 8'd1; room_d = room_q - 7'd1;
                  if (room_d != '0 && left_d != '0) begin
                    phase_d = M_WR_WAIT; uop_d = U_WAIT;
                  end else begin
                    phase_d = M_WR_STOP; uop_d = U_STOP;
                  end
                end
              end
              M_WR_STOP: begin poll_d = '0; phase_d = M_PL_START; uop_d = U_START; end
              M_PL_START: begin phase_d = M_PL_ADDR; uop_d = U_TX; shift_d = aw; end
              M_PL_ADDR: begin phase_d = M_PL_STOP; uop_d = U_STOP; end
              M_PL_STOP: begin
                if (ack_d) begin
                  if (left_q != '0) begin
                    room_d = 7'(PageBytes - (addr_q % PageBytes));
                    phase_d = M_WR_START; uop_d = U_START;
                  end else begin
                    phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1; o.status = ST_OK;
                  end
                end else begin
                  poll_d = poll_q + 10'd1; phase_d = M_PL_GAP; uop_d = U_GAP;
                end
              end
              M_PL_GAP: begin
                if (poll_q >= plim) begin
                  phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1;
                  o.status = ST_TIMEOUT;
                end else begin phase_d = M_PL_START; uop_d = U_START; end
              end
              M_FAIL_STOP: begin
                phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1; o.status = ST_TIMEOUT;
              end
              default: begin
                phase_d = M_IDLE; uop_d = U_WAIT; o.done_res = 1'b1; o.status = ST_OK;
              end
            endcase
          end
        end
      end
    end
    o.busy_res = (phase_d != M_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE; uop_q <= U_WAIT; slot_q <= '0; tick_q <= '0;
      shift_q <= '0; addr_q <= '0; left_q <= '0; room_q <= '0; poll_q <= '0;
      rdy_q <= 1'b0; wr_q <= 1'b0; ack_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; uop_q <= uop_d; slot_q <= slot_d; tick_q <= tick_d;
      shift_q <= shift_d; addr_q <= addr_d; left_q <= left_d; room_q <= room_d;
      poll_q <= poll_d; rdy_q <= rdy_d; wr_q <= wr_d; ack_q <= ack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) res_o <= o;
  end
endmodule

// File: design/i2c_eeprom_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_master_top
// Two-wire serial memory master, one bus tick per input beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   in_item_t  (request, write byte, sampled SDA)
// out_ch    out  out_item_t (bus drive, read byte, status)
// cfg_ch    in   cfg_wr_t   (register index, data)
//
// Every input beat is one tick and yields one result beat; a beat is taken
// every cycle while the result register is empty or being drained.
// The result register is the only stage between the sides, so out ready
// gates in ready directly. Reset leaves the sequencer idle with default
// timing registers and the device unprobed.
module i2c_eeprom_master_top
  import iem_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  iem_if.sink   in_ch,
  iem_if.source out_ch,
  iem_if.sink   cfg_ch
);
  cfg_t      cfg;
  logic      out_valid_q;
  logic      step;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_q || out_ch.ready;
  assign step         = in_ch.valid && in_ch.ready;

  iem_cfg_regs u_cfg (
    .clk_i, .rst_ni,
    .wr_en_i(cfg_ch.valid),
    .wr_i   (cfg_ch.data),
    .cfg_o  (cfg)
  );

  iem_core u_core (
    .clk_i, .rst_ni,
    .cfg_i (cfg),
    .step_i(step),
    .in_i  (in_ch.data),
    .res_o (out_ch.data)
  );

  // The result beat stays valid until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_q;

`ifndef SYNTHESIS
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q) else $error("accepted beat left no result");
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.data.done_res |-> out_ch.data.status == ST_OK)
    else $error("status without done");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ch.data.done_res |-> !out_ch.data.busy_res)
    else $error("busy on done beat");
`endif
endmodule
